### design/ile_pkg.sv
// Shared types, sizes and request/status codes of the indexed list engine.
`default_nettype none

package ile_pkg;

  localparam int CAPACITY    = 64;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int MODE_W      = 3;
  localparam int POS_W       = 7;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam mode_t MODE_TAIL_INS = 3'd0;
  localparam mode_t MODE_HEAD_INS = 3'd1;
  localparam mode_t MODE_IDX_INS  = 3'd2;
  localparam mode_t MODE_READ     = 3'd3;
  localparam mode_t MODE_HEAD_DEL = 3'd4;
  localparam mode_t MODE_TAIL_DEL = 3'd5;
  localparam mode_t MODE_IDX_DEL  = 3'd6;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_INDEX = 2'd1;
  localparam status_t ST_EMPTY     = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  localparam data_t READ_BAD = -32'sd1;

endpackage

`default_nettype wire

### design/ile_if.sv
// Request and result channel interfaces of the indexed list engine.
`default_nettype none

interface ile_in_if;
  logic                          valid;
  logic                          ready;
  logic [ile_pkg::MODE_W-1:0]    mode;
  logic [ile_pkg::POS_W-1:0]     position;
  logic signed [ile_pkg::DATA_W-1:0] value;

  modport source (output valid, mode, position, value, input ready);
  modport sink   (input valid, mode, position, value, output ready);
endinterface

interface ile_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ile_pkg::DATA_W-1:0]  read_value;
  logic [ile_pkg::STATUS_W-1:0]       status;
  logic [ile_pkg::COUNT_OUT_W-1:0]    entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

`default_nettype wire

### design/indexed_list_engine.sv
// Indexed list engine: ordered list of signed entries held in one synchronous memory.
//
//   Channel   Direction  Contents
//   in_ch     sink       mode, position, value
//   out_ch    source     read_value, status, entry_count
//
// A refused request or an unused mode has its result registered at the edge
// that takes it. A read passes through S_RDWAIT; an insert or delete passes
// through S_MOVE once for each entry moved one place, then through S_FINISH.
// The memory's one read port and one write port move one entry
// per cycle. Reset empties the list at once. A result waits in the output
// register until taken; the next request is taken in the same cycle as that
// result leaves.
`default_nettype none

module indexed_list_engine (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ile_in_if.sink     in_ch,
  ile_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MOVE   = 4'b0010,
    S_FINISH = 4'b0100,
    S_RDWAIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [ile_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [ile_pkg::CNT_W-1:0]  left_r, left_nxt;
  logic [ile_pkg::ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ile_pkg::ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ile_pkg::ADDR_W-1:0] at_r, at_nxt;
  logic                       up_r, up_nxt;
  logic                       ins_r, ins_nxt;
  ile_pkg::data_t             val_r, val_nxt;

  logic                       out_valid_r, out_valid_nxt;
  ile_pkg::data_t             out_rv_r, out_rv_nxt;
  ile_pkg::status_t           out_st_r, out_st_nxt;
  logic [ile_pkg::COUNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  // Entry store and its read data register.
  logic [ile_pkg::DATA_W-1:0] mem [ile_pkg::CAPACITY];
  logic [ile_pkg::DATA_W-1:0] mem_rdata_r;
  logic                       mem_we;
  logic [ile_pkg::ADDR_W-1:0] mem_waddr;
  logic [ile_pkg::DATA_W-1:0] mem_wdata;
  logic [ile_pkg::ADDR_W-1:0] mem_raddr;

  logic                       accept;
  logic [ile_pkg::CMP_W-1:0]  pos_x, cnt_x;
  logic [ile_pkg::CNT_W-1:0]  at_c, moves_c;
  logic                       full_c, empty_c;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign pos_x   = ile_pkg::CMP_W'(in_ch.position);
  assign cnt_x   = ile_pkg::CMP_W'(count_r);
  assign full_c  = (count_r == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
  assign empty_c = (count_r == '0);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    at_nxt        = at_r;
    up_nxt        = up_r;
    ins_nxt       = ins_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rv_nxt    = out_rv_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_ptr_r;
    mem_wdata     = mem_rdata_r;
    mem_raddr     = rd_ptr_r;
    at_c          = '0;
    moves_c       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Immediate result unless the request goes on below.
          out_valid_nxt = 1'b1;
          out_rv_nxt    = '0;
          out_st_nxt    = ile_pkg::ST_OK;
          out_cnt_nxt   = ile_pkg::COUNT_OUT_W'(count_r);
          val_nxt       = in_ch.value;
          case (in_ch.mode)
            ile_pkg::MODE_TAIL_INS, ile_pkg::MODE_HEAD_INS, ile_pkg::MODE_IDX_INS: begin
              if (in_ch.mode == ile_pkg::MODE_TAIL_INS) begin
                at_c = count_r;
              end else if (in_ch.mode == ile_pkg::MODE_IDX_INS) begin
                at_c = ile_pkg::CNT_W'(in_ch.position);
              end
              if ((in_ch.mode == ile_pkg::MODE_IDX_INS) && (pos_x > cnt_x)) begin
                out_st_nxt = ile_pkg::ST_BAD_INDEX;
              end else if (full_c) begin
                out_st_nxt = ile_pkg::ST_FULL;
              end else begin
                out_valid_nxt = 1'b0;
                ins_nxt       = 1'b1;
                up_nxt        = 1'b1;
                at_nxt        = at_c[ile_pkg::ADDR_W-1:0];
                moves_c       = count_r - at_c;
                left_nxt      = moves_c;
                // Open the gap from the top down: read i-1, write i.
                mem_raddr     = ile_pkg::ADDR_W'(count_r - 1'b1);
                rd_ptr_nxt    = ile_pkg::ADDR_W'(count_r - 2'd2);
                wr_ptr_nxt    = count_r[ile_pkg::ADDR_W-1:0];
                state_nxt     = (moves_c != '0) ? S_MOVE : S_FINISH;
              end
            end
            ile_pkg::MODE_READ: begin
              if (pos_x < cnt_x) begin
                out_valid_nxt = 1'b0;
                mem_raddr     = in_ch.position[ile_pkg::ADDR_W-1:0];
                state_nxt     = S_RDWAIT;
              end else begin
                out_rv_nxt = ile_pkg::READ_BAD;
                out_st_nxt = ile_pkg::ST_BAD_INDEX;
              end
            end
            ile_pkg::MODE_HEAD_DEL, ile_pkg::MODE_TAIL_DEL, ile_pkg::MODE_IDX_DEL: begin
              if (in_ch.mode == ile_pkg::MODE_TAIL_DEL) begin
                at_c = count_r - 1'b1;
              end else if (in_ch.mode == ile_pkg::MODE_IDX_DEL) begin
                at_c = ile_pkg::CNT_W'(in_ch.position);
              end
              if (empty_c) begin
                out_st_nxt = ile_pkg::ST_EMPTY;
              end else if ((in_ch.mode == ile_pkg::MODE_IDX_DEL) && (pos_x >= cnt_x)) begin
                out_st_nxt = ile_pkg::ST_BAD_INDEX;
              end else begin
                out_valid_nxt = 1'b0;
                ins_nxt       = 1'b0;
                up_nxt        = 1'b0;
                at_nxt        = at_c[ile_pkg::ADDR_W-1:0];
                moves_c       = count_r - 1'b1 - at_c;
                left_nxt      = moves_c;
                // Close the gap from the bottom up: read i+1, write i.
                mem_raddr     = ile_pkg::ADDR_W'(at_c + 1'b1);
                rd_ptr_nxt    = ile_pkg::ADDR_W'(at_c + 2'd2);
                wr_ptr_nxt    = at_c[ile_pkg::ADDR_W-1:0];
                state_nxt     = (moves_c != '0) ? S_MOVE : S_FINISH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_r;
        mem_wdata = mem_rdata_r;
        mem_raddr = rd_ptr_r;
        left_nxt  = left_r - 1'b1;
        if (up_r) begin
          wr_ptr_nxt = wr_ptr_r - 1'b1;
          rd_ptr_nxt = rd_ptr_r - 1'b1;
        end else begin
          wr_ptr_nxt = wr_ptr_r + 1'b1;
          rd_ptr_nxt = rd_ptr_r + 1'b1;
        end
        if (left_r == ile_pkg::CNT_W'(1)) begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (ins_r) begin
          mem_we    = 1'b1;
          mem_waddr = at_r;
          mem_wdata = val_r;
          count_nxt = count_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
        end
        out_valid_nxt = 1'b1;
        out_rv_nxt    = '0;
        out_st_nxt    = ile_pkg::ST_OK;
        out_cnt_nxt   = ile_pkg::COUNT_OUT_W'(count_nxt);
        state_nxt     = S_IDLE;
      end

      S_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_rv_nxt    = mem_rdata_r;
        out_st_nxt    = ile_pkg::ST_OK;
        out_cnt_nxt   = ile_pkg::COUNT_OUT_W'(count_r);
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r    <= left_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    at_r      <= at_nxt;
    up_r      <= up_nxt;
    ins_r     <= ins_nxt;
    val_r     <= val_nxt;
    out_rv_r  <= out_rv_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_rv_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.entry_count = out_cnt_r;

endmodule

`default_nettype wire

### tb/indexed_list_engine_test.sv
// Self-checking testbench for the indexed list engine, with a driver, a monitor and a predictor.
`default_nettype none

module indexed_list_engine_test;
  import ile_pkg::*;

  localparam mode_t MODE_UNUSED     = 3'd7;
  localparam int    RANDOM_REQUESTS = 540;
  localparam int    CALM_TAIL       = 60;
  localparam int    LONG_HOLD       = 400;
  localparam int    CYCLE_LIMIT     = 400000;

  typedef struct {
    mode_t              mode;
    logic [POS_W-1:0]   position;
    data_t              value;
  } request_t;

  typedef struct {
    data_t                  read_value;
    status_t                status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } outcome_t;

  logic clk;
  logic rst_n;

  ile_in_if  in_ch ();
  ile_out_if out_ch ();

  indexed_list_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  request_t requests_queued[$];
  outcome_t results_due[$];
  data_t    list_q[$];

  int  failures       = 0;
  int  accepted_count = 0;
  int  results_seen   = 0;
  int  cycle_count    = 0;
  int  src_gap_left   = 0;
  int  src_gap_pct    = 10;
  int  sink_stall_left = 0;
  int  sink_stall_pct  = 10;
  int  sink_hold_left  = 0;
  bit  calm_tail      = 1'b0;

  // Applies one request to the list held here and returns the result it should give.
  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int       n;
    int       at;
    n = list_q.size();
    o.read_value = '0;
    o.status     = ST_OK;
    case (r.mode)
      MODE_TAIL_INS, MODE_HEAD_INS, MODE_IDX_INS: begin
        at = (r.mode == MODE_TAIL_INS) ? n : (r.mode == MODE_HEAD_INS) ? 0 : int'(r.position);
        if (at > n) o.status = ST_BAD_INDEX;
        else if (n >= CAPACITY) o.status = ST_FULL;
        else list_q.insert(at, r.value);
      end
      MODE_READ: begin
        if (int'(r.position) < n) begin
          o.read_value = list_q[r.position];
        end else begin
          o.read_value = READ_BAD;
          o.status     = ST_BAD_INDEX;
        end
      end
      MODE_HEAD_DEL, MODE_TAIL_DEL, MODE_IDX_DEL: begin
        at = (r.mode == MODE_HEAD_DEL) ? 0 : (r.mode == MODE_TAIL_DEL) ? n - 1 : int'(r.position);
        // An empty list is reported before any index problem.
        if (n == 0) o.status = ST_EMPTY;
        else if (at >= n) o.status = ST_BAD_INDEX;
        else list_q.delete(at);
      end
      default: ;
    endcase
    o.entry_count = COUNT_OUT_W'(list_q.size());
    return o;
  endfunction

  function automatic int idle_share();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  function automatic data_t draw_value();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return data_t'($urandom());
  endfunction

  task automatic queue_request(mode_t m, int p, data_t v);
    request_t r;
    r.mode     = m;
    r.position = POS_W'(p);
    r.value    = v;
    requests_queued.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Driver: offers queued requests, with bursts of idle cycles between them.
  always @(posedge clk) begin : drive
    request_t taken;
    request_t nxt;
    bit       offer;
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.mode     <= MODE_TAIL_INS;
      in_ch.position <= '0;
      in_ch.value    <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.mode     = in_ch.mode;
        taken.position = in_ch.position;
        taken.value    = in_ch.value;
        results_due.push_back(apply_request(taken));
        accepted_count++;
        if (accepted_count % 64 == 0) src_gap_pct = idle_share();
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = 1'b0;
        if (src_gap_left > 0) begin
          src_gap_left--;
        end else if (requests_queued.size() != 0) begin
          if (!calm_tail && $urandom_range(0, 99) < src_gap_pct)
            src_gap_left = $urandom_range(0, 18);
          else
            offer = 1'b1;
        end
        if (offer) begin
          nxt = requests_queued.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.mode     <= nxt.mode;
          in_ch.position <= nxt.position;
          in_ch.value    <= nxt.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
        if (requests_queued.size() <= CALM_TAIL) calm_tail = 1'b1;
      end
    end
  end

  // Monitor: takes results, checks them in order and stalls the engine now and then.
  always @(posedge clk) begin : observe
    outcome_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $error("result with no request outstanding: read_value %0d, status %0d, count %0d",
                 out_ch.read_value, out_ch.status, out_ch.entry_count);
          failures++;
        end else begin
          want = results_due.pop_front();
          if (out_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_ch.read_value);
            failures++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            failures++;
          end
          if (out_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, out_ch.entry_count);
            failures++;
          end
        end
        results_seen++;
        // One long hold-off keeps a result waiting, so the engine takes no further requests.
        if (results_seen == 150) sink_hold_left = LONG_HOLD;
        if (results_seen % 64 == 0) sink_stall_pct = idle_share();
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_stall_left > 0) begin
        sink_stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 99) < sink_stall_pct) begin
        sink_stall_left = $urandom_range(0, 18);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int    gen_cnt;
    bit    growing;
    bit    noise;
    int    k;
    int    r;
    int    p;
    mode_t m;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_TAIL_INS;
    in_ch.position = '0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;

    // Directed part: empty-list cases first, then extremes of values and positions.
    queue_request(MODE_READ,     0,   0);
    queue_request(MODE_HEAD_DEL, 0,   0);
    queue_request(MODE_TAIL_DEL, 0,   0);
    queue_request(MODE_IDX_DEL,  127, 0);
    queue_request(MODE_UNUSED,   127, -32'sd1);
    queue_request(MODE_IDX_INS,  1,   5);
    queue_request(MODE_TAIL_INS, 0,   32'sh7fff_ffff);
    queue_request(MODE_TAIL_DEL, 0,   0);
    queue_request(MODE_IDX_INS,  0,   32'sh8000_0000);
    queue_request(MODE_HEAD_INS, 0,   32'sh7fff_ffff);
    queue_request(MODE_TAIL_INS, 0,   0);
    queue_request(MODE_IDX_INS,  3,   -32'sd1);
    queue_request(MODE_IDX_INS,  2,   32'sh5555_5555);
    queue_request(MODE_IDX_INS,  127, 32'sh2aaa_aaaa);
    queue_request(MODE_READ,     0,   0);
    queue_request(MODE_READ,     4,   0);
    queue_request(MODE_READ,     5,   0);
    queue_request(MODE_READ,     127, 0);
    queue_request(MODE_IDX_DEL,  5,   0);
    queue_request(MODE_IDX_DEL,  2,   0);
    queue_request(MODE_HEAD_DEL, 0,   0);
    queue_request(MODE_TAIL_DEL, 0,   0);
    queue_request(MODE_READ,     1,   0);
    queue_request(MODE_UNUSED,   42,  32'shaaaa_aaaa);

    // Random part: the list is filled until full and drained until empty, over and over.
    // Well-formed requests keep gen_cnt exact; malformed ones never change the list.
    gen_cnt = 2;
    growing = 1'b1;
    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      if (growing && gen_cnt == CAPACITY && $urandom_range(0, 7) == 0) growing = 1'b0;
      else if (!growing && gen_cnt == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      r     = $urandom_range(0, 99);
      noise = ($urandom_range(0, 99) < 12);
      p     = $urandom_range(0, 127);
      if (r < 2)
        m = MODE_UNUSED;
      else if (r < (growing ? 84 : 14))
        m = mode_t'($urandom_range(MODE_TAIL_INS, MODE_IDX_INS));
      else if (r < (growing ? 94 : 32))
        m = MODE_READ;
      else
        m = mode_t'($urandom_range(MODE_HEAD_DEL, MODE_IDX_DEL));

      if (m == MODE_IDX_INS) begin
        p = noise ? $urandom_range(gen_cnt + 1, 127) : $urandom_range(0, gen_cnt);
      end else if ((m == MODE_READ || m == MODE_IDX_DEL) && gen_cnt > 0) begin
        p = noise ? $urandom_range(gen_cnt, 127) : $urandom_range(0, gen_cnt - 1);
      end else begin
        noise = 1'b0;
      end
      if (m == MODE_READ || m == MODE_UNUSED) noise = 1'b1;

      if (!noise) begin
        if (m <= MODE_IDX_INS && gen_cnt < CAPACITY) gen_cnt++;
        else if (m >= MODE_HEAD_DEL && m <= MODE_IDX_DEL && gen_cnt > 0) gen_cnt--;
      end
      queue_request(m, p, draw_value());
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_queued.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(posedge clk);
    // Leave room for any stray result after the last expected one.
    repeat (CAPACITY + 8) @(posedge clk);

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
